// File: rtl/cvm_pkg.sv
`default_nettype none

package cvm_pkg;

  // default number of voices
  localparam int VOICES_DEF = 4;

  // item kinds (s_tuser)
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ENV    = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_RESET  = 2'd3;

  // voice register selects
  localparam logic [2:0] REG_FREQ    = 3'd0;
  localparam logic [2:0] REG_SHAPE   = 3'd1;
  localparam logic [2:0] REG_PWIDTH  = 3'd2;
  localparam logic [2:0] REG_ATTACK  = 3'd3;
  localparam logic [2:0] REG_DECAY   = 3'd4;
  localparam logic [2:0] REG_SUSTAIN = 3'd5;
  localparam logic [2:0] REG_RELEASE = 3'd6;
  localparam logic [2:0] REG_STAGE   = 3'd7;

  // waveform codes
  localparam logic [1:0] SHAPE_TRI   = 2'd0;
  localparam logic [1:0] SHAPE_PULSE = 2'd1;
  localparam logic [1:0] SHAPE_SAW   = 2'd2;
  localparam logic [1:0] SHAPE_NOISE = 2'd3;

  // envelope stages (zero and three both mean release)
  localparam logic [1:0] STAGE_RELEASE = 2'd0;
  localparam logic [1:0] STAGE_ATTACK  = 2'd1;
  localparam logic [1:0] STAGE_DECAY   = 2'd2;

  // constants
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] NOISE_DROP = 16'd16384;
  localparam logic [14:0] AMP_PEAK   = 15'h7fff;
  localparam logic [7:0]  WAVE_MID   = 8'd128;
  localparam logic [7:0]  WAVE_HALF  = 8'd64;

  // stored state of one voice
  typedef struct packed {
    logic [15:0] phase;
    logic [15:0] step;
    logic [1:0]  shape;
    logic [7:0]  pthr;
    logic [7:0]  attack;
    logic [7:0]  decay;
    logic [7:0]  sustain;
    logic [7:0]  release_rate;
    logic [1:0]  stage;
    logic [14:0] amp;
    logic [7:0]  held;
  } voice_t;

  // results of one pass of the voice unit
  typedef struct packed {
    logic [15:0]        phase;
    logic [7:0]         held;
    logic signed [7:0]  value;
    logic [14:0]        amp;
    logic [1:0]         stage;
  } voice_upd_t;

endpackage

`default_nettype wire

// File: rtl/cvm_voice_alu.sv
`default_nettype none

module cvm_voice_alu
  import cvm_pkg::*;
(
  input  voice_t      vs,
  input  logic [15:0] lfsr,
  output voice_upd_t  upd
);

  logic [15:0] phase_sum;
  logic [7:0]  ph;
  logic [16:0] att_sum;
  logic [14:0] lvl;
  logic [16:0] dec_diff;
  logic [16:0] rel_diff;

  // oscillator: advance phase, pick waveform value; then envelope step
  always_comb begin
    phase_sum = vs.phase + vs.step;
    ph        = phase_sum[15:8];
    upd.phase = phase_sum;
    upd.held  = vs.held;
    unique case (vs.shape)
      SHAPE_TRI: begin
        if (ph < 8'd128) upd.value = $signed(ph - WAVE_HALF);
        else             upd.value = $signed(8'd192 - ph);
      end
      SHAPE_PULSE: begin
        upd.value = (ph < vs.pthr) ? $signed(8'd0 - WAVE_HALF) : $signed(WAVE_HALF - 8'd1);
      end
      SHAPE_SAW: begin
        upd.value = $signed({1'b0, ph[7:1]} - WAVE_HALF);
      end
      default: begin
        // noise: resample the shared register once phase passes a quarter
        if (ph > 8'd64) begin
          upd.held  = {1'b0, lfsr[15:9]} - WAVE_HALF;
          upd.phase = phase_sum - NOISE_DROP;
        end
        upd.value = $signed(upd.held);
      end
    endcase

    // envelope step
    att_sum  = {2'b00, vs.amp} + {1'b0, vs.attack, 8'h00};
    lvl      = vs.sustain[7] ? AMP_PEAK : {vs.sustain[6:0], 8'h00};
    dec_diff = {2'b00, vs.amp} - {1'b0, vs.decay, 8'h00};
    rel_diff = {2'b00, vs.amp} - {5'b0, vs.release_rate, 4'h0};
    upd.amp   = vs.amp;
    upd.stage = vs.stage;
    unique case (vs.stage)
      STAGE_ATTACK: begin
        if (att_sum >= {2'b00, AMP_PEAK}) begin
          upd.amp   = AMP_PEAK;
          upd.stage = STAGE_DECAY;
        end else begin
          upd.amp = att_sum[14:0];
        end
      end
      STAGE_DECAY: begin
        if ($signed(dec_diff) < $signed({2'b00, lvl})) upd.amp = lvl;
        else                                           upd.amp = dec_diff[14:0];
      end
      default: begin
        if (rel_diff[16]) upd.amp = '0;
        else              upd.amp = rel_diff[14:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/chiptune_voice_mixer_adsr.sv
// channel | dir | tdata (low bit up)                   | tuser
// s_*     | in  | voice[1:0] reg_sel[4:2] wdata[20:5]  | kind[1:0]
// m_*     | out | sample[7:0]                          | -
//
// Sample tick: an accept step, one pass per voice on the shared voice unit and
// multiplier, then a scale/output step that waits for a free output register.
// Envelope tick: accept, one pass per voice. Register write, voice reset: accept.
// Reset (rst, synchronous) clears all voice state and seeds the noise LFSR.
// A sample waits in the output register; a new tick stalls only in the last
// step while the previous sample is not taken.
`default_nettype none

module chiptune_voice_mixer_adsr
  import cvm_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // voice[1:0], reg_sel[4:2], wdata[20:5], zero pad
  input  wire  [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata    // sample[7:0]
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SAMP = 2'd1;
  localparam logic [1:0] ST_ENV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  voice_t      vst [VOICES];
  logic [15:0] lfsr;
  logic [15:0] lfsr_next;
  logic [1:0]  state;
  logic [VW-1:0] cnt;
  logic signed [16:0] mix;
  logic signed [16:0] mix_next;
  logic signed [15:0] prod;
  voice_upd_t  upd;
  logic        s_fire;
  logic [1:0]  s_voice;
  logic [2:0]  s_reg;
  logic [15:0] s_wdata;
  logic signed [16:0] scaled;
  logic signed [16:0] third;
  logic signed [16:0] third10;
  logic [7:0]  sample;

  assign s_voice  = s_tdata[1:0];
  assign s_reg    = s_tdata[4:2];
  assign s_wdata  = s_tdata[20:5];
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // noise register step
  assign lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);

  // shared voice unit on the voice under the counter
  cvm_voice_alu u_alu (
    .vs   (vst[cnt]),
    .lfsr (lfsr),
    .upd  (upd)
  );

  // value times amplitude, accumulated
  assign prod     = upd.value * $signed({1'b0, vst[cnt].amp[14:8]});
  assign mix_next = mix + 17'(prod);

  // scale by voice count (above four voices as for four), offset to unsigned
  always_comb begin
    third   = mix >>> 6;
    third10 = (third <<< 3) + (third <<< 1);
    if (VOICES == 1)      scaled = mix >>> 6;
    else if (VOICES == 2) scaled = mix >>> 7;
    else if (VOICES == 3) scaled = third10 >>> 5;
    else                  scaled = mix >>> 8;
    sample = scaled[7:0] + WAVE_MID;
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICES; i++) vst[i] <= '0;
      lfsr     <= LFSR_SEED;
      state    <= ST_IDLE;
      cnt      <= '0;
      mix      <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      // the final step reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_FIN)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (s_tuser)
              KIND_SAMPLE: begin
                lfsr  <= lfsr_next;
                cnt   <= '0;
                mix   <= '0;
                state <= ST_SAMP;
              end
              KIND_ENV: begin
                cnt   <= '0;
                state <= ST_ENV;
              end
              KIND_WRITE: begin
                if (32'(s_voice) < VOICES) begin
                  unique case (s_reg)
                    REG_FREQ:    vst[s_voice[VW-1:0]].step         <= s_wdata;
                    REG_SHAPE:   vst[s_voice[VW-1:0]].shape        <= s_wdata[1:0];
                    REG_PWIDTH:  vst[s_voice[VW-1:0]].pthr         <= s_wdata[7:0];
                    REG_ATTACK:  vst[s_voice[VW-1:0]].attack       <= s_wdata[7:0];
                    REG_DECAY:   vst[s_voice[VW-1:0]].decay        <= s_wdata[7:0];
                    REG_SUSTAIN: vst[s_voice[VW-1:0]].sustain      <= s_wdata[7:0];
                    REG_RELEASE: vst[s_voice[VW-1:0]].release_rate <= s_wdata[7:0];
                    default:     vst[s_voice[VW-1:0]].stage        <= s_wdata[1:0];
                  endcase
                end
              end
              default: begin
                for (int i = 0; i < VOICES; i++) begin
                  vst[i].phase <= '0;
                  vst[i].step  <= '0;
                  vst[i].stage <= STAGE_RELEASE;
                end
              end
            endcase
          end
        end
        ST_SAMP: begin
          vst[cnt].phase <= upd.phase;
          vst[cnt].held  <= upd.held;
          mix            <= mix_next;
          if (cnt == LAST) state <= ST_FIN;
          else             cnt   <= cnt + VW'(1);
        end
        ST_ENV: begin
          vst[cnt].amp   <= upd.amp;
          vst[cnt].stage <= upd.stage;
          if (cnt == LAST) state <= ST_IDLE;
          else             cnt   <= cnt + VW'(1);
        end
        default: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= sample;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/cvm_checker.sv
`default_nettype none

module cvm_checker
  import cvm_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [1:0]  s_tuser,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // a sample tick keeps the block busy in the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_SAMPLE) |=> !s_tready)
    else $error("ready right after a sample tick");

  // writes and voice resets finish in their accept cycle
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && ((s_tuser == KIND_WRITE) || (s_tuser == KIND_RESET))
    |=> s_tready)
    else $error("not ready after a register write or voice reset");

  // reset leaves the block idle with no pending word
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

endmodule

bind chiptune_voice_mixer_adsr cvm_checker u_cvm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
